### hw/rtl/teh_pkg.sv
// ----------------------------------------------------------------------------
// teh_pkg
// Shared constants, types and state codes of the two-channel history block.
// ----------------------------------------------------------------------------
package teh_pkg;

    localparam int LEVEL_FRAC_BITS = 16;
    localparam int LEVEL_BITS      = LEVEL_FRAC_BITS + 1;
    localparam int DURATION_BITS   = 16;
    localparam int TAU_BITS        = 24;
    localparam int NUM_BITS        = DURATION_BITS + 8;
    localparam int CODE_BITS       = 4;
    localparam int DIV_BITS        = 32;
    localparam int DIV_CNT_BITS    = $clog2(DIV_BITS);
    localparam int TERM_COUNT      = 13;
    localparam int SQUARE_COUNT    = 5;
    localparam int Q31_SHIFT       = 31;
    localparam int F_SHIFT         = Q31_SHIFT - LEVEL_FRAC_BITS;

    localparam logic [LEVEL_BITS-1:0] ONE_LEVEL = LEVEL_BITS'(1) << LEVEL_FRAC_BITS;

    // configuration register indexes
    localparam logic [1:0] CFG_TAU   = 2'd0;
    localparam logic [1:0] CFG_MIXED = 2'd1;
    localparam logic [1:0] CFG_MIXACT = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIVZ,
        ST_MULT,
        ST_TSTART,
        ST_TDIV,
        ST_SQ,
        ST_SQR,
        ST_FIN,
        ST_UPD0,
        ST_UPD0R,
        ST_UPD1,
        ST_UPD1R,
        ST_DONE
    } teh_state_t;

    typedef struct packed {
        logic [CODE_BITS-1:0]     code;
        logic [DURATION_BITS-1:0] dur;
    } teh_req_t;

    typedef struct packed {
        logic                  valid;
        logic [LEVEL_BITS-1:0] other;
        logic [LEVEL_BITS-1:0] same;
    } teh_res_t;

    typedef struct packed {
        logic [TAU_BITS-1:0]  tau;
        logic [CODE_BITS-1:0] mixed;
        logic                 mixact;
    } teh_cfg_t;

endpackage

### hw/rtl/two_channel_exponential_history_top.sv
// ----------------------------------------------------------------------------
// two_channel_exponential_history_top
// Two-channel leaky integrator: reports both history levels per channel event,
// then charges or decays each by e^(-256*duration/tau).
//
//   channel   dir  handshake              payload
//   s_*       in   s_tvalid / s_tready    tdata: state_code, duration
//   m_*       out  m_tvalid / m_tready    tdata: same, other; tuser: valid
//   cfg_*     in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An event runs from one request to the next through 14 bit-serial divisions
// (32 quotient bits and a done strobe each), a multiply and a launch step per
// series term, the squarings, a rounding of the factor, the four level-update
// states, a hand-off and a return to idle.
// When the factor is known zero or tau is zero it goes straight to the updates.
// Reset clears both levels and loads tau 256, mixed code 3, mixing passive.
// A result waits in the output register; the next event may start meanwhile,
// and the engine stalls at its end until that register is free.
// ----------------------------------------------------------------------------
module two_channel_exponential_history_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // state_code[3:0], duration[19:4], zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // same_history[16:0], other_history[33:17], zero
    output logic [0:0]  m_tuser,    // history_valid[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    teh_pkg::teh_cfg_t cfg_reg;
    teh_pkg::teh_req_t req;
    teh_pkg::teh_res_t eng_res;
    teh_pkg::teh_res_t out_reg;
    logic              out_valid_reg;
    logic              eng_idle;
    logic              eng_ready;
    logic              load;
    logic              s_accept;

    assign s_accept = s_tvalid && s_tready;
    assign s_tready = eng_idle;
    assign req.code = s_tdata[3:0];
    assign req.dur  = s_tdata[19:4];
    assign load     = eng_ready && (!out_valid_reg || m_tready);

    teh_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .start     (s_accept),
        .req       (req),
        .idle      (eng_idle),
        .res_ready (eng_ready),
        .res       (eng_res),
        .res_taken (load)
    );

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tau    <= teh_pkg::TAU_BITS'(256);
            cfg_reg.mixed  <= teh_pkg::CODE_BITS'(3);
            cfg_reg.mixact <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                teh_pkg::CFG_TAU:    cfg_reg.tau    <= cfg_data;
                teh_pkg::CFG_MIXED:  cfg_reg.mixed  <= cfg_data[3:0];
                teh_pkg::CFG_MIXACT: cfg_reg.mixact <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= eng_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_reg.other, out_reg.same};
    assign m_tuser  = out_reg.valid;

endmodule

### hw/rtl/teh_serdiv.sv
// ----------------------------------------------------------------------------
// teh_serdiv
// Bit-serial restoring divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module teh_serdiv
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [teh_pkg::TAU_BITS-1:0]     init_rem,
    input  logic [teh_pkg::DIV_BITS-1:0]     dividend,
    input  logic [teh_pkg::TAU_BITS-1:0]     divisor,
    output logic                             done,
    output logic [teh_pkg::DIV_BITS-1:0]     quotient
);

    logic                                busy_reg;
    logic                                done_reg;
    logic [teh_pkg::DIV_CNT_BITS-1:0]    cnt_reg;
    logic [teh_pkg::TAU_BITS-1:0]        rem_reg;
    logic [teh_pkg::TAU_BITS-1:0]        dsr_reg;
    logic [teh_pkg::DIV_BITS-1:0]        qd_reg;
    logic [teh_pkg::TAU_BITS:0]          trial;
    logic                                qbit;

    // trial subtract of the shifted partial remainder
    always_comb
    begin
        trial = {rem_reg, qd_reg[teh_pkg::DIV_BITS-1]};
        qbit  = (trial >= {1'b0, dsr_reg});
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == teh_pkg::DIV_CNT_BITS'(teh_pkg::DIV_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // dividend bits shift out at the top, quotient bits shift in at the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= init_rem;
            dsr_reg <= divisor;
            qd_reg  <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= qbit ? teh_pkg::TAU_BITS'(trial - {1'b0, dsr_reg})
                            : teh_pkg::TAU_BITS'(trial);
            qd_reg  <= {qd_reg[teh_pkg::DIV_BITS-2:0], qbit};
        end
    end

    assign done     = done_reg;
    assign quotient = qd_reg;

endmodule

### hw/rtl/teh_engine.sv
// ----------------------------------------------------------------------------
// teh_engine
// Sequencer for decay factor (serial division, Taylor series, squarings)
// and the two channel level updates.
// ----------------------------------------------------------------------------
module teh_engine
(
    input  logic                clk,
    input  logic                rst_n,
    input  teh_pkg::teh_cfg_t   cfg,
    input  logic                start,
    input  teh_pkg::teh_req_t   req,
    output logic                idle,
    output logic                res_ready,
    output teh_pkg::teh_res_t   res,
    input  logic                res_taken
);

    localparam int LB = teh_pkg::LEVEL_BITS;

    teh_pkg::teh_state_t state_reg, state_next;

    logic [LB-1:0]                    lvl0_reg, lvl0_next;
    logic [LB-1:0]                    lvl1_reg, lvl1_next;
    teh_pkg::teh_res_t                res_reg;
    logic [1:0]                       act_reg;
    logic [31:0]                      term_reg;
    logic [30:0]                      z_reg;
    logic [33:0]                      pos_reg;
    logic [33:0]                      neg_reg;
    logic [31:0]                      e_reg;
    logic [3:0]                       k_reg;
    logic [2:0]                       sq_reg;
    logic [LB-1:0]                    f_reg;
    logic [63:0]                      prod_reg;

    logic [teh_pkg::NUM_BITS-1:0]     num;
    logic                             f_zero;
    logic                             div_start;
    logic [teh_pkg::TAU_BITS-1:0]     div_init;
    logic [teh_pkg::DIV_BITS-1:0]     div_dvd;
    logic [teh_pkg::TAU_BITS-1:0]     div_dsr;
    logic                             div_done;
    logic [teh_pkg::DIV_BITS-1:0]     div_q;
    logic [31:0]                      mul_a;
    logic [31:0]                      mul_b;
    logic [LB-1:0]                    h0c;
    logic [LB-1:0]                    h1c;
    logic [LB-1:0]                    upd_r;
    logic [1:0]                       act_in;

    teh_serdiv u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .init_rem (div_init),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .quotient (div_q)
    );

    // operand preparation
    always_comb
    begin
        num    = teh_pkg::NUM_BITS'(req.dur) << 8;
        f_zero = ({5'b0, num} >= ({5'b0, cfg.tau} << 5));
        h0c    = (lvl0_reg > teh_pkg::ONE_LEVEL) ? teh_pkg::ONE_LEVEL : lvl0_reg;
        h1c    = (lvl1_reg > teh_pkg::ONE_LEVEL) ? teh_pkg::ONE_LEVEL : lvl1_reg;
        upd_r  = LB'((prod_reg + 64'(teh_pkg::ONE_LEVEL >> 1)) >> teh_pkg::LEVEL_FRAC_BITS);
        act_in[0] = (req.code == teh_pkg::CODE_BITS'(1)) ||
                    ((req.code == cfg.mixed) && cfg.mixact);
        act_in[1] = (req.code == teh_pkg::CODE_BITS'(2)) ||
                    ((req.code == cfg.mixed) && cfg.mixact);
    end

    // next state, divider and multiplier control
    always_comb
    begin
        state_next = state_reg;
        lvl0_next  = lvl0_reg;
        lvl1_next  = lvl1_reg;
        div_start  = 1'b0;
        div_init   = '0;
        div_dvd    = prod_reg[62:31];
        div_dsr    = teh_pkg::TAU_BITS'(k_reg);
        mul_a      = term_reg;
        mul_b      = {1'b0, z_reg};
        unique case (state_reg)
            teh_pkg::ST_IDLE:
            begin
                div_init = teh_pkg::TAU_BITS'(num >> 6);
                div_dvd  = {num[5:0], 26'b0};
                div_dsr  = cfg.tau;
                if (start)
                begin
                    if (cfg.tau == '0 || f_zero)
                        state_next = teh_pkg::ST_UPD0;
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = teh_pkg::ST_DIVZ;
                    end
                end
            end
            teh_pkg::ST_DIVZ:
                if (div_done)
                    state_next = teh_pkg::ST_MULT;
            teh_pkg::ST_MULT:
                state_next = teh_pkg::ST_TSTART;
            teh_pkg::ST_TSTART:
            begin
                div_start  = 1'b1;
                state_next = teh_pkg::ST_TDIV;
            end
            teh_pkg::ST_TDIV:
                if (div_done)
                    state_next = (k_reg == 4'(teh_pkg::TERM_COUNT)) ? teh_pkg::ST_SQ
                                                                     : teh_pkg::ST_MULT;
            teh_pkg::ST_SQ:
            begin
                mul_a      = e_reg;
                mul_b      = e_reg;
                state_next = teh_pkg::ST_SQR;
            end
            teh_pkg::ST_SQR:
                state_next = (sq_reg == 3'(teh_pkg::SQUARE_COUNT - 1)) ? teh_pkg::ST_FIN
                                                                        : teh_pkg::ST_SQ;
            teh_pkg::ST_FIN:
                state_next = teh_pkg::ST_UPD0;
            teh_pkg::ST_UPD0:
            begin
                mul_a      = 32'(act_reg[0] ? teh_pkg::ONE_LEVEL - h0c : h0c);
                mul_b      = 32'(f_reg);
                state_next = teh_pkg::ST_UPD0R;
            end
            teh_pkg::ST_UPD0R:
            begin
                lvl0_next  = act_reg[0] ? teh_pkg::ONE_LEVEL - upd_r : upd_r;
                state_next = teh_pkg::ST_UPD1;
            end
            teh_pkg::ST_UPD1:
            begin
                mul_a      = 32'(act_reg[1] ? teh_pkg::ONE_LEVEL - h1c : h1c);
                mul_b      = 32'(f_reg);
                state_next = teh_pkg::ST_UPD1R;
            end
            teh_pkg::ST_UPD1R:
            begin
                lvl1_next  = act_reg[1] ? teh_pkg::ONE_LEVEL - upd_r : upd_r;
                state_next = teh_pkg::ST_DONE;
            end
            teh_pkg::ST_DONE:
                if (res_taken)
                    state_next = teh_pkg::ST_IDLE;
            default:
                state_next = teh_pkg::ST_IDLE;
        endcase
    end

    // state and channel levels
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= teh_pkg::ST_IDLE;
            lvl0_reg  <= '0;
            lvl1_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lvl0_reg  <= lvl0_next;
            lvl1_reg  <= lvl1_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
        case (state_reg)
            teh_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    act_reg <= act_in;
                    if (req.code == teh_pkg::CODE_BITS'(1))
                    begin
                        res_reg.same  <= lvl0_reg;
                        res_reg.other <= lvl1_reg;
                        res_reg.valid <= 1'b1;
                    end
                    else if (req.code == teh_pkg::CODE_BITS'(2))
                    begin
                        res_reg.same  <= lvl1_reg;
                        res_reg.other <= lvl0_reg;
                        res_reg.valid <= 1'b1;
                    end
                    else
                    begin
                        res_reg <= '0;
                    end
                    // zero tau: one for zero duration, else zero
                    if (cfg.tau == '0)
                        f_reg <= (req.dur == '0) ? teh_pkg::ONE_LEVEL : '0;
                    else
                        f_reg <= '0;
                end
            end
            teh_pkg::ST_DIVZ:
            begin
                z_reg    <= div_q[30:0];
                term_reg <= 32'h8000_0000;
                pos_reg  <= 34'h0_8000_0000;
                neg_reg  <= '0;
                k_reg    <= 4'd1;
                sq_reg   <= '0;
            end
            teh_pkg::ST_TDIV:
            begin
                if (div_done)
                begin
                    term_reg <= div_q;
                    if (k_reg[0])
                        neg_reg <= neg_reg + 34'(div_q);
                    else
                        pos_reg <= pos_reg + 34'(div_q);
                    if (k_reg == 4'(teh_pkg::TERM_COUNT))
                    begin
                        if (k_reg[0])
                            e_reg <= 32'(pos_reg - neg_reg - 34'(div_q));
                        else
                            e_reg <= 32'(pos_reg + 34'(div_q) - neg_reg);
                    end
                    k_reg <= k_reg + 4'd1;
                end
            end
            teh_pkg::ST_SQR:
            begin
                e_reg  <= 32'((prod_reg + 64'h4000_0000) >> teh_pkg::Q31_SHIFT);
                sq_reg <= sq_reg + 3'd1;
            end
            teh_pkg::ST_FIN:
                f_reg <= LB'((33'(e_reg) + 33'(1 << (teh_pkg::F_SHIFT - 1)))
                             >> teh_pkg::F_SHIFT);
            default:
            begin
            end
        endcase
    end

    assign idle      = (state_reg == teh_pkg::ST_IDLE);
    assign res_ready = (state_reg == teh_pkg::ST_DONE);
    assign res       = res_reg;

`ifndef SYNTH
    // levels stay within zero to one
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        lvl0_reg <= teh_pkg::ONE_LEVEL && lvl1_reg <= teh_pkg::ONE_LEVEL)
        else $error("channel level above one");

    // new work only when idle
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == teh_pkg::ST_IDLE)
        else $error("request taken while busy");

    // a waiting result holds until taken
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == teh_pkg::ST_DONE && !res_taken)
        |=> (state_reg == teh_pkg::ST_DONE && $stable(res_reg)))
        else $error("result changed before taken");

    // factor never above one
    a_f_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == teh_pkg::ST_UPD0) |-> f_reg <= teh_pkg::ONE_LEVEL)
        else $error("decay factor above one");
`endif

endmodule

### test/history_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// history_checker
// Watches the event, result and register channels of the two-channel history
// block, predicts each result from its own copy of the levels and registers,
// and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module history_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic [0:0]  m_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    output int          fail_count,
    output int          pending_count
);

    localparam logic [63:0] Q31_ONE = 64'd1 << teh_pkg::Q31_SHIFT;

    logic [teh_pkg::TAU_BITS-1:0]   tau_copy;
    logic [teh_pkg::CODE_BITS-1:0]  mixed_copy;
    logic                           mixact_copy;
    logic [teh_pkg::LEVEL_BITS-1:0] level [2];
    teh_pkg::teh_res_t              expected_results [$];
    int                             mismatches;

    assign fail_count = mismatches;

    // e^(-256*dur/tau) with one equal to ONE_LEVEL
    function automatic logic [63:0] decay_factor(logic [63:0] dur, logic [63:0] tau);
        logic [63:0] num;
        logic [63:0] z;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] e;
        if (tau == 0)
            return (dur == 0) ? 64'(teh_pkg::ONE_LEVEL) : 64'd0;
        num = dur << 8;
        if (num / tau >= 32)
            return 64'd0;
        z    = ((num << 32) / tau) >> 6;
        term = Q31_ONE;
        pos  = Q31_ONE;
        neg  = 0;
        for (int k = 1; k <= teh_pkg::TERM_COUNT; k++)
        begin
            term = ((term * z) >> teh_pkg::Q31_SHIFT) / k;
            if (k % 2 == 1)
                neg += term;
            else
                pos += term;
        end
        e = pos - neg;
        for (int k = 0; k < teh_pkg::SQUARE_COUNT; k++)
            e = (e * e + (Q31_ONE >> 1)) >> teh_pkg::Q31_SHIFT;
        return (e + (64'd1 << (teh_pkg::F_SHIFT - 1))) >> teh_pkg::F_SHIFT;
    endfunction

    function automatic logic charges(logic [teh_pkg::CODE_BITS-1:0] code, int chan);
        if (code == teh_pkg::CODE_BITS'(chan + 1))
            return 1'b1;
        if (code == mixed_copy)
            return mixact_copy;
        return 1'b0;
    endfunction

    // predict on each accepted event, check on each accepted result
    always @(posedge clk or negedge rst_n)
    begin
        logic [teh_pkg::CODE_BITS-1:0]     code;
        logic [teh_pkg::DURATION_BITS-1:0] dur;
        logic [63:0]                       f;
        logic [63:0]                       h;
        logic [63:0]                       one;
        teh_pkg::teh_res_t                 res;
        teh_pkg::teh_res_t                 got;
        int                                errs;
        if (!rst_n)
        begin
            tau_copy      <= 24'd256;
            mixed_copy    <= 4'd3;
            mixact_copy   <= 1'b0;
            level[0]      <= '0;
            level[1]      <= '0;
            mismatches    <= 0;
            pending_count <= 0;
            expected_results.delete();
        end
        else
        begin
            errs = 0;
            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    teh_pkg::CFG_TAU:    tau_copy    <= cfg_data;
                    teh_pkg::CFG_MIXED:  mixed_copy  <= cfg_data[teh_pkg::CODE_BITS-1:0];
                    teh_pkg::CFG_MIXACT: mixact_copy <= cfg_data[0];
                    default:             ;
                endcase
            end
            // event request
            if (s_tvalid && s_tready)
            begin
                code = s_tdata[3:0];
                dur  = s_tdata[19:4];
                res  = '0;
                if (code == 4'd1 || code == 4'd2)
                begin
                    res.same  = level[code - 1];
                    res.other = level[2 - code];
                    res.valid = 1'b1;
                end
                expected_results.push_back(res);
                f   = decay_factor(64'(dur), 64'(tau_copy));
                one = 64'(teh_pkg::ONE_LEVEL);
                for (int c = 0; c < 2; c++)
                begin
                    h = 64'(level[c]);
                    if (h > one)
                        h = one;
                    if (charges(code, c))
                        h = one - (((one - h) * f + (one >> 1)) >> teh_pkg::LEVEL_FRAC_BITS);
                    else
                        h = (h * f + (one >> 1)) >> teh_pkg::LEVEL_FRAC_BITS;
                    level[c] <= h[teh_pkg::LEVEL_BITS-1:0];
                end
            end
            // result request
            if (m_tvalid && m_tready)
            begin
                got.same  = m_tdata[16:0];
                got.other = m_tdata[33:17];
                got.valid = m_tuser[0];
                if (expected_results.size() == 0)
                begin
                    $error("result with no event outstanding");
                    errs = errs + 1;
                end
                else
                begin
                    res = expected_results.pop_front();
                    if (got.same !== res.same)
                    begin
                        $error("same_history expected %0d actual %0d", res.same, got.same);
                        errs = errs + 1;
                    end
                    if (got.other !== res.other)
                    begin
                        $error("other_history expected %0d actual %0d", res.other, got.other);
                        errs = errs + 1;
                    end
                    if (got.valid !== res.valid)
                    begin
                        $error("history_valid expected %0d actual %0d", res.valid, got.valid);
                        errs = errs + 1;
                    end
                end
            end
            mismatches    <= mismatches + errs;
            pending_count <= expected_results.size();
        end
    end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives events and register writes into the two-channel history block under
// several settings and idling patterns; the checker beside it predicts and
// compares every result.
// ----------------------------------------------------------------------------
module testbench;

    localparam int  RUN_LIMIT   = 20_000_000;
    localparam int  DRAIN_WAIT  = 1200;
    localparam int  PHASE_ITEMS = 237;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;

    int          fail_count;
    int          pending_count;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    int          cycle_count = 0;
    logic        hold_req = 1'b0;
    logic        hold_taken = 1'b0;
    int          hold_left = 0;
    logic [3:0]  mixed_now = 4'd3;

    always #4 clk = ~clk;

    two_channel_exponential_history_top u_top (.*);

    history_checker u_checker (.*);

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver: random stalls plus one long hold-off
    always @(posedge clk)
    begin
        if (hold_req && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_left  <= 4000;
            m_tready   <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    task automatic send_event(input logic [3:0] code, input logic [15:0] dur);
        s_tdata  <= {4'd0, dur, code};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // let the checker count the last accepted request before polling pending_count
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic set_regs(input logic [23:0] tau, input logic [3:0] mixed, input logic act);
        wait_idle();
        write_reg(teh_pkg::CFG_TAU, tau);
        write_reg(teh_pkg::CFG_MIXED, mixed);
        write_reg(teh_pkg::CFG_MIXACT, {23'd0, act});
        mixed_now = mixed;
    endtask

    // mostly random channel events, some mixed, some arbitrary codes
    function automatic logic [3:0] pick_code();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70)
            return 4'($urandom_range(1, 2));
        if (sel < 85)
            return mixed_now;
        return 4'($urandom_range(15));
    endfunction

    // durations spread around tau so both the charge and the saturation show up
    function automatic logic [15:0] pick_duration();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(255));
            2: return 16'($urandom_range(15));
            default: return 16'($urandom_range(0, 65535 >> $urandom_range(15)));
        endcase
    endfunction

    initial
    begin
        logic [23:0] tau_pick;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset registers, extremes, mixed and invalid codes
        send_event(4'd1, 16'd0);
        send_event(4'd1, 16'd256);
        send_event(4'd2, 16'd100);
        send_event(4'd1, 16'd65535);
        send_event(4'd2, 16'd8191);
        send_event(4'd3, 16'd50);
        send_event(4'd0, 16'd300);
        send_event(4'd15, 16'hAAAA);
        send_event(4'd2, 16'h5555);
        send_event(4'd1, 16'd0);
        set_regs(24'd4096, 4'd3, 1'b1);
        send_event(4'd3, 16'd200);
        send_event(4'd1, 16'd16);
        send_event(4'd2, 16'd1);
        // mixed code that names a channel
        set_regs(24'd1000, 4'd1, 1'b1);
        send_event(4'd1, 16'd500);
        send_event(4'd2, 16'd300);
        set_regs(24'd1000, 4'd2, 1'b0);
        send_event(4'd2, 16'd700);
        send_event(4'd1, 16'd40);
        // zero tau
        set_regs(24'd0, 4'd7, 1'b1);
        send_event(4'd1, 16'd0);
        send_event(4'd2, 16'd5);
        send_event(4'd7, 16'd0);
        // tau extremes
        set_regs(24'hFFFFFF, 4'd15, 1'b0);
        send_event(4'd1, 16'd65535);
        send_event(4'd2, 16'd1);
        set_regs(24'd1, 4'd0, 1'b1);
        send_event(4'd2, 16'd1);
        send_event(4'd1, 16'd0);

        // random phases across settings and idling patterns
        for (int p = 0; p < 8; p++)
        begin
            case (p % 5)
                0: tau_pick = 24'($urandom_range(64, 8192));
                1: tau_pick = 24'hFFFFFF;
                2: tau_pick = 24'd1;
                3: tau_pick = 24'd256;
                default: tau_pick = 24'($urandom_range(1, 24'hFFFFFF));
            endcase
            set_regs(tau_pick, 4'($urandom_range(15)), p[0]);
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 60; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 60; end
                default: begin tx_idle_pct = 37; rx_stall_pct = 37; end
            endcase
            if (p == 2)
                hold_req = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_event(pick_code(), pick_duration());
        end

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
